// ----- hw/rtl/sine_cosine_polynomial_unit_assert.svh -----
// Assertion macros shared by the checker of the sine/cosine unit.
// All properties are sampled on the rising edge of i_clk.
`ifndef SINE_COSINE_POLYNOMIAL_UNIT_ASSERT_SVH
`define SINE_COSINE_POLYNOMIAL_UNIT_ASSERT_SVH

// Implication that holds in the same cycle, ignored while reset is held.
`define SCP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sine/cosine unit check failed");

// Implication whose consequence is checked a fixed number of cycles later.
`define SCP_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) \
        else $error("sine/cosine unit latency check failed");

// Invariant that holds at every edge, reset included.
`define SCP_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge i_clk) (expr)) \
        else $error("sine/cosine unit invariant failed");

`endif

// ----- hw/rtl/scp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Widths, fixed-point constants and pipeline side-band types of the
// sine/cosine polynomial unit.
// ----------------------------------------------------------------------------
package scp_pkg;

    // Range reduction works on the angle in Q.32 plus a positive offset.
    localparam int U_W   = 41;
    localparam int R_W   = 35;
    localparam int RDC_N = 6;

    localparam logic [U_W-1:0] TAU_Q32    = 41'd26986075409;
    localparam logic [U_W-1:0] ANGLE_OFS  = 41'd593693658998;   // 22 * 2pi
    localparam logic [R_W-1:0] PI_Q32     = 35'd13493037705;
    localparam logic [R_W-1:0] HALFPI_Q32 = 35'd6746518852;
    localparam logic [R_W-1:0] PI3H_Q32   = 35'd20239556557;
    localparam logic [R_W-1:0] TAU_R      = 35'd26986075409;

    // Folded magnitude, t and s widths.
    localparam int MAG_W = 33;
    localparam int T_W   = 32;
    localparam int S_W   = 32;

    // Horner accumulator and product widths.
    localparam int ACC_W  = 34;
    localparam int PROD_W = ACC_W + S_W + 1;
    localparam int HRN_N  = 5;

    localparam logic signed [ACC_W-1:0] SIN_C0 = -34'sd103;
    localparam logic signed [ACC_W-1:0] COS_C0 = -34'sd1119;

    // Addend of each Horner step; the last step adds one in Q.32.
    localparam logic signed [ACC_W-1:0] SIN_ADD [HRN_N] = '{
        34'sd11822, -34'sd852160, 34'sd35791386, -34'sd715827882, 34'sd4294967296
    };
    localparam logic signed [ACC_W-1:0] COS_ADD [HRN_N] = '{
        34'sd106347, -34'sd5965021, 34'sd178956864, -34'sd2147483632, 34'sd4294967296
    };

    typedef struct packed {
        logic vld;
        logic req;
    } t_rdc_side;

    typedef struct packed {
        logic           vld;
        logic           req;
        logic           neg;
        logic [T_W-1:0] t;
    } t_hrn_side;

endpackage

// ----- hw/rtl/sine_cosine_polynomial_unit.sv -----
`timescale 1ns / 1ps
// A result strobes on o_valid once its transfer has passed the input register,
// the six-cell reduction row, fold, round, square and square-rounding registers,
// the five two-stage Horner cells and four output stages.
// Throughput: one angle per cycle; busy is low whenever reset is released.
// Reset is synchronous and active low; it clears all valid flags, holds busy
// high and drops items in flight. The receiver cannot stall the results.
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_unit
// Sine or cosine of a Q8.24 angle by range reduction, quadrant folding and a
// fifth-order Horner polynomial in the squared angle; Q2.30 result.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    output logic signed [31:0] o_value
);
    import scp_pkg::*;

    localparam int TP_W = T_W + 1 + ACC_W;
    localparam int VR_W = 35;

    localparam logic signed [ACC_W-1:0] P_HALF      = 34'sd2;
    localparam logic signed [TP_W-1:0]  TP_HALF     = {{(TP_W-32){1'b0}}, 1'b1, 31'd0};
    localparam logic signed [VR_W-1:0]  ONE_Q30     = 35'sd1073741824;
    localparam logic signed [VR_W-1:0]  NEG_ONE_Q30 = -35'sd1073741824;

    logic accept;

    // Offset angle in Q.32, always positive.
    logic [U_W-1:0] n_u;
    logic [U_W-1:0] r_u;
    t_rdc_side      r_rdc_side;

    logic [U_W-1:0] u_chain    [RDC_N+1];
    t_rdc_side      rside_chain [RDC_N+1];

    // Fold stage.
    logic [R_W-1:0]   n_r;
    logic             n_lt_pi;
    logic             n_gt_pi;
    logic             n_gt_half;
    logic             n_gt_3half;
    logic [R_W-1:0]   n_mag;
    logic             n_neg;
    logic [MAG_W-1:0] r_mag;
    logic             r_fold_vld;
    logic             r_fold_req;
    logic             r_fold_neg;

    // Rounding to Q.30, squaring.
    logic [MAG_W:0]     n_tsum;
    t_hrn_side          r_t_side;
    logic [2*T_W-1:0]   r_sq;
    t_hrn_side          r_sq_side;
    logic [2*T_W:0]     n_ssum;
    logic [S_W-1:0]     r_s;
    t_hrn_side          r_s_side;

    logic signed [ACC_W-1:0] acc_chain  [HRN_N+1];
    logic [S_W-1:0]          s_chain    [HRN_N+1];
    t_hrn_side               hside_chain [HRN_N+1];

    // Output stages.
    logic signed [TP_W-1:0]  r_tp;
    logic signed [ACC_W-1:0] r_p;
    t_hrn_side               r_m_side;
    logic signed [ACC_W-1:0] n_pr;
    logic signed [ACC_W-1:0] n_pv;
    logic signed [TP_W-1:0]  n_tps;
    logic signed [TP_W-1:0]  n_tpv;
    logic signed [VR_W-1:0]  n_vr;
    logic signed [VR_W-1:0]  r_vr;
    logic                    r_r_vld;
    logic                    r_r_neg;
    logic signed [31:0]      n_vc;
    logic signed [31:0]      r_vc;
    logic                    r_c_vld;
    logic                    r_c_neg;
    logic signed [31:0]      r_value;
    logic                    r_out_vld;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_comb begin
        n_u = {i_angle[31], i_angle, 8'd0} + ANGLE_OFS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdc_side.vld <= 1'b0;
        end else begin
            r_rdc_side.vld <= accept;
            r_rdc_side.req <= i_req_type;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
    end

    assign u_chain[0]     = r_u;
    assign rside_chain[0] = r_rdc_side;

    // Binary restoring reduction: subtract 32, 16, 8, 4, 2 and 1 times 2pi.
    for (genvar g = 0; g < RDC_N; g++) begin : g_rdc
        scp_rdc_cell u_rdc_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_u     (u_chain[g]),
            .i_sub   (TAU_Q32 << (RDC_N - 1 - g)),
            .i_side  (rside_chain[g]),
            .o_u     (u_chain[g+1]),
            .o_side  (rside_chain[g+1])
        );
    end

    // Quadrant fold. Exactly pi/2 stays unfolded; pi and 3pi/2 fold to r - pi.
    always_comb begin
        n_r        = u_chain[RDC_N][R_W-1:0];
        n_lt_pi    = n_r < PI_Q32;
        n_gt_pi    = n_r > PI_Q32;
        n_gt_half  = n_r > HALFPI_Q32;
        n_gt_3half = n_r > PI3H_Q32;
        if (n_lt_pi) begin
            n_mag = n_gt_half ? (PI_Q32 - n_r) : n_r;
        end else begin
            n_mag = n_gt_3half ? (TAU_R - n_r) : (n_r - PI_Q32);
        end
        // Cosine takes the quadrant sign, sine the sign of the folded angle.
        if (rside_chain[RDC_N].req) begin
            n_neg = n_lt_pi ? n_gt_half : ~n_gt_3half;
        end else begin
            n_neg = n_gt_pi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_vld <= 1'b0;
        end else begin
            r_fold_vld <= rside_chain[RDC_N].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fold_req <= rside_chain[RDC_N].req;
        r_fold_neg <= n_neg;
        r_mag      <= n_mag[MAG_W-1:0];
    end

    always_comb begin
        n_tsum = {1'b0, r_mag} + (MAG_W+1)'(2);
        n_ssum = {1'b0, r_sq} + (2*T_W+1)'(1 << 29);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_side.vld  <= 1'b0;
            r_sq_side.vld <= 1'b0;
            r_s_side.vld  <= 1'b0;
        end else begin
            r_t_side.vld  <= r_fold_vld;
            r_sq_side.vld <= r_t_side.vld;
            r_s_side.vld  <= r_sq_side.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_side.req  <= r_fold_req;
        r_t_side.neg  <= r_fold_neg;
        r_t_side.t    <= n_tsum[MAG_W:2];
        r_sq          <= r_t_side.t * r_t_side.t;
        r_sq_side.req <= r_t_side.req;
        r_sq_side.neg <= r_t_side.neg;
        r_sq_side.t   <= r_t_side.t;
        r_s           <= n_ssum[30 +: S_W];
        r_s_side.req  <= r_sq_side.req;
        r_s_side.neg  <= r_sq_side.neg;
        r_s_side.t    <= r_sq_side.t;
    end

    assign acc_chain[0]   = r_s_side.req ? COS_C0 : SIN_C0;
    assign s_chain[0]     = r_s;
    assign hside_chain[0] = r_s_side;

    for (genvar h = 0; h < HRN_N; h++) begin : g_hrn
        scp_hrn_cell u_hrn_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_acc     (acc_chain[h]),
            .i_s       (s_chain[h]),
            .i_side    (hside_chain[h]),
            .i_add_sin (SIN_ADD[h]),
            .i_add_cos (COS_ADD[h]),
            .o_acc     (acc_chain[h+1]),
            .o_s       (s_chain[h+1]),
            .o_side    (hside_chain[h+1])
        );
    end

    always_comb begin
        n_pr  = r_p + P_HALF;
        n_pv  = n_pr >>> 2;
        n_tps = r_tp + TP_HALF;
        n_tpv = n_tps >>> 32;
        n_vr  = r_m_side.req ? VR_W'(n_pv) : $signed(n_tpv[VR_W-1:0]);
    end

    // Clamping is symmetric, so the sign can be applied afterwards.
    always_comb begin
        if (r_vr > ONE_Q30) begin
            n_vc = ONE_Q30[31:0];
        end else if (r_vr < NEG_ONE_Q30) begin
            n_vc = NEG_ONE_Q30[31:0];
        end else begin
            n_vc = r_vr[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_side.vld <= 1'b0;
            r_r_vld      <= 1'b0;
            r_c_vld      <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_m_side.vld <= hside_chain[HRN_N].vld;
            r_r_vld      <= r_m_side.vld;
            r_c_vld      <= r_r_vld;
            r_out_vld    <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tp         <= $signed({1'b0, hside_chain[HRN_N].t}) * acc_chain[HRN_N];
        r_p          <= acc_chain[HRN_N];
        r_m_side.req <= hside_chain[HRN_N].req;
        r_m_side.neg <= hside_chain[HRN_N].neg;
        r_m_side.t   <= hside_chain[HRN_N].t;
        r_vr         <= n_vr;
        r_r_neg      <= r_m_side.neg;
        r_vc         <= n_vc;
        r_c_neg      <= r_r_neg;
        r_value      <= r_c_neg ? -r_vc : r_vc;
    end

    assign o_valid = r_out_vld;
    assign o_value = r_value;

endmodule

// ----- hw/rtl/scp_rdc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_rdc_cell
// One step of the modulo-2pi reduction: subtracts a fixed multiple of 2pi
// when the running value is at least that large, then registers the result.
// ----------------------------------------------------------------------------
module scp_rdc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [scp_pkg::U_W-1:0]   i_u,
    input  logic [scp_pkg::U_W-1:0]   i_sub,
    input  scp_pkg::t_rdc_side        i_side,
    output logic [scp_pkg::U_W-1:0]   o_u,
    output scp_pkg::t_rdc_side        o_side
);
    import scp_pkg::*;

    logic [U_W:0]   n_diff;
    logic [U_W-1:0] n_u;
    logic [U_W-1:0] r_u;
    t_rdc_side      r_side;

    always_comb begin
        n_diff = {1'b0, i_u} - {1'b0, i_sub};
        n_u    = n_diff[U_W] ? i_u : n_diff[U_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.vld <= 1'b0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
    end

    assign o_u    = r_u;
    assign o_side = r_side;

endmodule

// ----- hw/rtl/scp_hrn_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_hrn_cell
// One Horner step: acc * s in the first register stage, then rounding to
// Q.32 and adding the sine or cosine coefficient in the second.
// ----------------------------------------------------------------------------
module scp_hrn_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic signed [scp_pkg::ACC_W-1:0] i_acc,
    input  logic [scp_pkg::S_W-1:0]         i_s,
    input  scp_pkg::t_hrn_side              i_side,
    input  logic signed [scp_pkg::ACC_W-1:0] i_add_sin,
    input  logic signed [scp_pkg::ACC_W-1:0] i_add_cos,
    output logic signed [scp_pkg::ACC_W-1:0] o_acc,
    output logic [scp_pkg::S_W-1:0]         o_s,
    output scp_pkg::t_hrn_side              o_side
);
    import scp_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF_LSB = {{(PROD_W-30){1'b0}}, 1'b1, 29'd0};

    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic [S_W-1:0]           r_s1;
    t_hrn_side                r_side1;

    logic signed [PROD_W-1:0] n_sum;
    logic signed [PROD_W-1:0] n_rnd;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  r_acc;
    logic [S_W-1:0]           r_s2;
    t_hrn_side                r_side2;

    always_comb begin
        n_prod = i_acc * $signed({1'b0, i_s});
    end

    // Arithmetic shift of the biased product rounds to nearest, ties upward.
    always_comb begin
        n_sum = r_prod + HALF_LSB;
        n_rnd = n_sum >>> 30;
        n_acc = $signed(n_rnd[ACC_W-1:0]) + (r_side1.req ? i_add_cos : i_add_sin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.vld <= 1'b0;
            r_side2.vld <= 1'b0;
        end else begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_s1   <= i_s;
        r_acc  <= n_acc;
        r_s2   <= r_s1;
    end

    assign o_acc  = r_acc;
    assign o_s    = r_s2;
    assign o_side = r_side2;

endmodule

// ----- hw/rtl/scp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks of the sine/cosine unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sine_cosine_polynomial_unit_assert.svh"

module scp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_req_type,
    input logic signed [31:0] i_angle,
    input logic               o_valid,
    input logic signed [31:0] o_value
);

    localparam int                 LAT = 25;
    localparam logic signed [31:0] ONE = 32'sd1073741824;

    // The unit refuses transfers exactly while reset is held.
    `SCP_ASSERT_ALWAYS(a_busy_in_reset, busy == !i_rst_n)

    `SCP_ASSERT_IMPL(a_value_range, o_valid, (o_value <= ONE) && (o_value >= -ONE))

    // Every transfer yields one strobe after the fixed latency, and no other.
    `SCP_ASSERT_DELAY(a_latency, start && !busy, LAT, o_valid)
    `SCP_ASSERT_IMPL(a_no_spurious, o_valid, $past(start && !busy, LAT))

    // The sine of a zero angle is exactly zero.
    `SCP_ASSERT_DELAY(a_sine_zero, start && !busy && !i_req_type && (i_angle == 0), LAT, o_value == 0)

endmodule

bind sine_cosine_polynomial_unit scp_checker u_scp_checker (.*);
